// ===== sv/sawb_pkg.sv =====
package sawb_pkg;

  localparam int unsigned AddrW     = 32;
  localparam int unsigned StampW    = 64;
  localparam int unsigned DefSets   = 256;
  localparam int unsigned DefWays   = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [CfgIdxW-1:0] RegMode   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegOffset = 2'd1;
  localparam logic [CfgIdxW-1:0] RegIndex  = 2'd2;

  typedef struct packed {
    logic             command;
    logic [AddrW-1:0] address;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic [2:0]       way_used;
    logic             fetch_valid;
    logic [AddrW-1:0] fetch_address;
    logic             writeback_valid;
    logic [AddrW-1:0] writeback_address;
  } rsp_t;

endpackage

// ===== sv/set_assoc_writeback_cache_ctrl_unit.sv =====
// A miss and a hit each give one result strobe; one comparator walks the ways in order, and a
// hit ends the walk early. A new request is taken only when idle, after the last result is out.
// Reset clears the access clock and sets the configuration registers to their defaults, then
// busy stays high while a pass clears every line entry of the one-read-port memory.
// The receiver cannot stall: each result strobe is high for exactly one cycle.
module set_assoc_writeback_cache_ctrl_unit
  import sawb_pkg::*;
#(
  parameter int unsigned Sets = DefSets,
  parameter int unsigned Ways = DefWays
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  sawb_pkg::req_t                    req_i,
  output logic                              done,
  output sawb_pkg::rsp_t                    rsp_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sawb_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [sawb_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned SetW   = (Sets > 1) ? $clog2(Sets) : 1;
  localparam int unsigned MaxIw  = $clog2(Sets + 1) - 1;
  localparam int unsigned WayW   = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned WCntW  = $clog2(Ways + 1);
  localparam int unsigned Lines  = Sets * Ways;
  localparam int unsigned LineW  = $clog2(Lines) > 0 ? $clog2(Lines) : 1;
  localparam int unsigned EntW   = AddrW + StampW + 2;

  typedef enum logic [5:0] {
    StClear = 6'b000001,
    StIdle  = 6'b000010,
    StRead  = 6'b000100,
    StScan  = 6'b001000,
    StWrite = 6'b010000,
    StDone  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic             mode_q;
  logic [2:0]       ow_q;
  logic [3:0]       iw_q;
  logic             cmd_q;
  logic [AddrW-1:0] addr_q;
  logic [SetW-1:0]  set_q;
  logic [AddrW-1:0] tag_q;
  logic [4:0]       shift_q;
  logic [StampW-1:0] clock_q;
  logic [WCntW-1:0] wcnt_q;
  logic             hit_q, inv_q;
  logic [WayW-1:0]  way_q;
  logic [StampW-1:0] best_q;
  logic [AddrW-1:0] vtag_q;
  logic             vdirty_q;
  logic             rvalid_q;
  rsp_t             rsp_q;
  logic             done_q;
  logic [LineW-1:0] clr_q;

  logic [3:0]       iw_eff;
  logic [SetW-1:0]  set_c;
  logic [LineW-1:0] raddr, waddr;
  logic [EntW-1:0]  rdata, wdata;
  logic             we;
  logic [AddrW-1:0] ent_tag;
  logic [StampW-1:0] ent_stamp;
  logic             ent_valid, ent_dirty;
  logic [WayW-1:0]  scan_way;

  assign iw_eff = (iw_q > 4'(MaxIw)) ? 4'(MaxIw) : iw_q;
  assign set_c  = SetW'((req_i.address >> ow_q) & ((32'd1 << iw_eff) - 32'd1));

  assign scan_way = rvalid_q ? WayW'(wcnt_q - WCntW'(1)) : WayW'(0);
  assign raddr    = LineW'(set_q * Ways + wcnt_q[WayW-1:0]);
  assign waddr    = (state_q == StClear) ? clr_q : LineW'(set_q * Ways + way_q);
  assign {ent_tag, ent_stamp, ent_valid, ent_dirty} = rdata;

  sawb_way_store #(.Depth(Lines), .Width(EntW)) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign busy        = (state_q != StIdle);
  assign cfg_ready_o = (state_q == StIdle);
  assign done        = done_q;
  assign rsp_o       = rsp_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (clr_q == LineW'(Lines - 1)) state_d = StIdle;
      StIdle:  if (start) state_d = StRead;
      StRead:  state_d = StScan;
      StScan:  if (hit_q || (rvalid_q && wcnt_q == WCntW'(Ways))) state_d = StWrite;
      StWrite: state_d = StDone;
      StDone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    wdata = '0;
    if (state_q == StClear) begin
      we = 1'b1;
    end else if (state_q == StWrite) begin
      we    = 1'b1;
      wdata = {tag_q, (hit_q && mode_q) ? best_q : clock_q, 1'b1,
               cmd_q | (hit_q & vdirty_q)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StClear;
      mode_q   <= 1'b0;
      ow_q     <= 3'd5;
      iw_q     <= 4'd8;
      clock_q  <= '0;
      clr_q    <= '0;
      done_q   <= 1'b0;
      rvalid_q <= 1'b0;
      wcnt_q   <= '0;
      hit_q    <= 1'b0;
      inv_q    <= 1'b0;
      way_q    <= '0;
      best_q   <= '0;
      vtag_q   <= '0;
      vdirty_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          RegMode:   mode_q <= cfg_data_i[0];
          RegOffset: ow_q   <= cfg_data_i[2:0];
          RegIndex:  iw_q   <= cfg_data_i[3:0];
          default:   ;
        endcase
      end
      unique case (state_q)
        StClear: begin
          clr_q <= clr_q + LineW'(1);
        end
        StIdle: begin
          if (start) begin
            wcnt_q   <= '0;
            rvalid_q <= 1'b0;
            hit_q    <= 1'b0;
            inv_q    <= 1'b0;
            vdirty_q <= 1'b0;
          end
        end
        StRead: begin
          wcnt_q   <= wcnt_q + WCntW'(1);
          rvalid_q <= 1'b1;
        end
        StScan: begin
          if (!hit_q && wcnt_q != WCntW'(Ways)) begin
            wcnt_q <= wcnt_q + WCntW'(1);
          end
          if (rvalid_q && !hit_q) begin
            if (ent_valid && ent_tag == tag_q) begin
              hit_q    <= 1'b1;
              way_q    <= scan_way;
              best_q   <= ent_stamp;
              vdirty_q <= ent_dirty;
            end else if (!inv_q) begin
              if (!ent_valid) begin
                inv_q <= 1'b1;
                way_q <= scan_way;
              end else if (scan_way == '0 || ent_stamp < best_q) begin
                best_q   <= ent_stamp;
                way_q    <= scan_way;
                vtag_q   <= ent_tag;
                vdirty_q <= ent_dirty;
              end
            end
          end
        end
        StWrite: begin
          clock_q <= clock_q + StampW'(1);
          done_q  <= 1'b1;
        end
        StDone: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start) begin
      cmd_q   <= req_i.command;
      addr_q  <= req_i.address;
      set_q   <= set_c;
      tag_q   <= req_i.address >> (5'(ow_q) + 5'(iw_eff));
      shift_q <= 5'(ow_q) + 5'(iw_eff);
    end
    if (state_q == StWrite) begin
      rsp_q.hit             <= hit_q;
      rsp_q.way_used        <= 3'(way_q);
      rsp_q.fetch_valid     <= !hit_q;
      rsp_q.fetch_address   <= hit_q ? '0 : ((addr_q >> ow_q) << ow_q);
      rsp_q.writeback_valid <= !hit_q && !inv_q && vdirty_q;
      rsp_q.writeback_address <= (!hit_q && !inv_q && vdirty_q) ?
          ((vtag_q << shift_q) | (AddrW'(set_q) << ow_q)) : '0;
    end
  end

  a_done_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> !done) else $error("result strobe held");
  a_done_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> state_q == StDone) else $error("strobe out of sequence");
  a_busy_no_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !cfg_ready_o) else $error("config open while busy");

endmodule

// ===== sv/sawb_way_store.sv =====
module sawb_way_store #(
  parameter int unsigned Depth = 2048,
  parameter int unsigned Width = 96
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
